### src/nddi_pkg.sv
`timescale 1ns / 1ps

package nddi_pkg;

    localparam int CW   = 6;
    localparam int DW   = 32;
    localparam int MAGW = 2 * DW + 2;

    localparam logic [2:0] ST_TAKEN     = 3'd0;
    localparam logic [2:0] ST_READY     = 3'd1;
    localparam logic [2:0] ST_ZERO_DIV  = 3'd2;
    localparam logic [2:0] ST_SAT       = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;

    localparam logic [MAGW-1:0] NEG_LIM = MAGW'(64'h0000_0000_8000_0000);
    localparam logic [MAGW-1:0] POS_LIM = MAGW'(64'h0000_0000_7fff_ffff);

    typedef struct packed {
        logic [DW-1:0] value;
        logic          sat;
    } arith_res_t;

    // apply sign to a magnitude and clamp to the signed 32 bit range
    function automatic arith_res_t sat_mag(input logic neg, input logic [MAGW-1:0] m);
        arith_res_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (m > NEG_LIM) begin
                r.sat   = 1'b1;
                r.value = {1'b1, {(DW-1){1'b0}}};
            end
            else begin
                r.value = DW'(0) - m[DW-1:0];
            end
        end
        else begin
            if (m > POS_LIM) begin
                r.sat   = 1'b1;
                r.value = {1'b0, {(DW-1){1'b1}}};
            end
            else begin
                r.value = m[DW-1:0];
            end
        end
        return r;
    endfunction

endpackage

### src/nddi_if.sv
`timescale 1ns / 1ps

interface nddi_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] query_x;

    modport source (output valid, mode, node_x, node_y, query_x, input ready);
    modport sink   (input valid, mode, node_x, node_y, query_x, output ready);
endinterface

interface nddi_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

### src/nddi_mul.sv
`timescale 1ns / 1ps

module nddi_mul
    import nddi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] a,
    input  logic [DW:0]   b,
    output logic          done,
    output arith_res_t    res
);

    localparam int CNTW = $clog2(DW + 1);

    logic [MAGW-1:0] p_reg;
    logic [MAGW-1:0] p_next;
    logic [DW-1:0]   ma_reg;
    logic            neg_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            fin_reg;
    logic            done_reg;
    arith_res_t      res_reg;
    logic [DW+1:0]   part_sum;

    // shift-add: upper half accumulates, multiplier bits leave at the bottom
    assign part_sum = {1'b0, p_reg[MAGW-1:DW+1]} + (p_reg[0] ? {2'b00, ma_reg} : '0);
    assign p_next   = {part_sum, p_reg[DW:1]};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p_reg    <= '0;
            ma_reg   <= '0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                ma_reg   <= a[DW-1] ? DW'(0) - a : a;
                p_reg    <= {{(DW+1){1'b0}}, (b[DW] ? (DW+1)'(0) - b : b)};
                neg_reg  <= a[DW-1] ^ b[DW];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                p_reg   <= p_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(DW)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg) begin
                fin_reg  <= 1'b0;
                res_reg  <= sat_mag(neg_reg, p_reg >> FRAC_BITS);
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### src/nddi_div.sv
`timescale 1ns / 1ps

module nddi_div
    import nddi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [DW:0] num,
    input  logic [DW:0] den,
    output logic        done,
    output arith_res_t  res
);

    localparam int NW   = DW + 1 + FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg;
    logic [DW:0]     rem_reg;
    logic [DW:0]     md_reg;
    logic            neg_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            fin_reg;
    logic            done_reg;
    arith_res_t      res_reg;
    logic [DW+1:0]   trial;
    logic [DW+1:0]   diff;
    logic            fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, q_reg[NW-1]};
    assign diff  = trial - {1'b0, md_reg};
    assign fits  = (trial >= {1'b0, md_reg});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            q_reg    <= '0;
            rem_reg  <= '0;
            md_reg   <= '0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= {(num[DW] ? (DW+1)'(0) - num : num), {FRAC_BITS{1'b0}}};
                md_reg   <= den[DW] ? (DW+1)'(0) - den : den;
                rem_reg  <= '0;
                neg_reg  <= num[DW] ^ den[DW];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                rem_reg <= fits ? diff[DW:0] : trial[DW:0];
                q_reg   <= {q_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg) begin
                fin_reg  <= 1'b0;
                res_reg  <= sat_mag(neg_reg, MAGW'(q_reg));
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### src/newton_divided_difference_interp.sv
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// req       in   valid / ready    mode, node_x, node_y, query_x
// rsp       out  valid / ready    value, status
// cfg       in   cfg_we           cfg_data (node_count)
//
// a load item that is not the last node is answered in the cycle after it is
// taken, as is a query before the table is built. the last load builds the
// table in place: n(n-1)/2 divisions on the shared radix-2 divider, where a
// step whose divisor is zero skips the divider. a query takes two passes of
// the serial shift-add multiplier per node. req.ready is low while an item
// works and while a result waits in the output register with rsp.ready low.
// reset clears the registers but not the node and coefficient memories,
// which need no clearing pass.

module newton_divided_difference_interp
    import nddi_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    nddi_req_if.sink      req,
    nddi_rsp_if.source    rsp,
    input  logic          cfg_we,
    input  logic [CW-1:0] cfg_data
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_A,
        S_B_B,
        S_B_C,
        S_B_W,
        S_E_A,
        S_E_B,
        S_E_RD,
        S_E_M1,
        S_E_W1,
        S_E_W2
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] node_count_reg;
    logic [CW-1:0] nodes_loaded_reg;
    logic          table_ready_reg;
    logic          out_valid_reg;
    logic [DW-1:0] out_value_reg;
    logic [2:0]    out_status_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic          zdiv_reg;
    logic          sat_reg;
    logic [DW-1:0] q_reg;
    logic [DW-1:0] prod_reg;
    logic [DW-1:0] acc_reg;
    logic [DW-1:0] cj_reg;
    logic [DW-1:0] ci_reg;
    logic [DW-1:0] xi_reg;

    // coefficient and abscissa memories
    logic [DW-1:0] c_mem [MAX_NODES];
    logic [DW-1:0] x_mem [MAX_NODES];
    logic [DW-1:0] c_rd_reg;
    logic [DW-1:0] x_rd_reg;
    logic          c_we;
    logic          x_we;
    logic [AW-1:0] c_waddr;
    logic [DW-1:0] c_wdata;
    logic [AW-1:0] c_raddr;
    logic [AW-1:0] x_raddr;

    logic [CW-1:0] n;
    logic [CW-1:0] n_m1;
    logic [CW-1:0] k_base;
    logic [CW-1:0] k;
    logic [CW-1:0] k_inc;
    logic [CW-1:0] i_m_j;
    logic [CW-1:0] j_m1;
    logic          acc_in;

    logic [DW:0]   num;
    logic [DW:0]   den;
    logic          den_zero;
    logic          step_done;
    logic          zdiv_now;
    logic          sat_now;

    logic          mul_start;
    logic [DW-1:0] mul_a;
    logic [DW:0]   mul_b;
    logic          mul_done;
    arith_res_t    mul_res;
    logic          div_start;
    logic          div_done;
    arith_res_t    div_res;

    logic [DW:0]   sum33;
    logic          sum_sat;
    logic [DW-1:0] sum_val;
    logic          q_sat;

    // effective node count, clamped to [2, MAX_NODES]
    always_comb begin
        if (node_count_reg < CW'(2)) begin
            n = CW'(2);
        end
        else if (int'(node_count_reg) > MAX_NODES) begin
            n = CW'(MAX_NODES);
        end
        else begin
            n = node_count_reg;
        end
    end

    assign n_m1   = n - 1'b1;
    assign k_base = table_ready_reg ? '0 : nodes_loaded_reg;
    assign k      = (k_base >= n) ? '0 : k_base;
    assign k_inc  = k + 1'b1;
    assign i_m_j  = i_reg - j_reg;
    assign j_m1   = j_reg - 1'b1;
    assign acc_in = req.valid && req.ready;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    // table build step: c[i] = (c[i] - c[i-1]) / (x[i] - x[i-j])
    assign num       = {ci_reg[DW-1], ci_reg} - {c_rd_reg[DW-1], c_rd_reg};
    assign den       = {xi_reg[DW-1], xi_reg} - {x_rd_reg[DW-1], x_rd_reg};
    assign den_zero  = (den == '0);
    assign div_start = (state_reg == S_B_C) && !den_zero;
    assign step_done = ((state_reg == S_B_C) && den_zero) || ((state_reg == S_B_W) && div_done);
    assign zdiv_now  = zdiv_reg || ((state_reg == S_B_C) && den_zero);
    assign sat_now   = sat_reg || ((state_reg == S_B_W) && div_done && div_res.sat);

    // evaluation: prod *= (q - x[j-1]), then acc += c[j] * prod
    always_comb begin
        mul_start = 1'b0;
        mul_a     = prod_reg;
        mul_b     = {q_reg[DW-1], q_reg} - {x_rd_reg[DW-1], x_rd_reg};
        if (state_reg == S_E_M1) begin
            mul_start = 1'b1;
        end
        else if ((state_reg == S_E_W1) && mul_done) begin
            mul_start = 1'b1;
            mul_a     = cj_reg;
            mul_b     = {mul_res.value[DW-1], mul_res.value};
        end
    end

    assign sum33   = {acc_reg[DW-1], acc_reg} + {mul_res.value[DW-1], mul_res.value};
    assign sum_sat = sum33[DW] ^ sum33[DW-1];
    assign sum_val = sum_sat ? (sum33[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                             : sum33[DW-1:0];
    assign q_sat   = sat_reg || mul_res.sat || sum_sat;

    // memory ports
    always_comb begin
        c_raddr = '0;
        x_raddr = '0;
        case (state_reg)
            S_B_A:
            begin
                c_raddr = i_reg[AW-1:0];
                x_raddr = i_reg[AW-1:0];
            end
            S_B_B:
            begin
                c_raddr = i_reg[AW-1:0] - AW'(1);
                x_raddr = i_m_j[AW-1:0];
            end
            S_E_RD:
            begin
                c_raddr = j_reg[AW-1:0];
                x_raddr = j_m1[AW-1:0];
            end
            default:
            begin
                c_raddr = '0;
                x_raddr = '0;
            end
        endcase
    end

    always_comb begin
        x_we    = 1'b0;
        c_we    = 1'b0;
        c_waddr = i_reg[AW-1:0];
        c_wdata = '0;
        if ((state_reg == S_IDLE) && acc_in && !req.mode) begin
            x_we    = 1'b1;
            c_we    = 1'b1;
            c_waddr = k[AW-1:0];
            c_wdata = req.node_y;
        end
        else if (step_done) begin
            c_we    = 1'b1;
            c_wdata = (state_reg == S_B_W) ? div_res.value : '0;
        end
    end

    always_ff @(posedge clk) begin
        if (c_we) begin
            c_mem[c_waddr] <= c_wdata;
        end
        if (x_we) begin
            x_mem[k[AW-1:0]] <= req.node_x;
        end
        c_rd_reg <= c_mem[c_raddr];
        x_rd_reg <= x_mem[x_raddr];
    end

    nddi_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    nddi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .res   (div_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            node_count_reg   <= CW'(32);
            nodes_loaded_reg <= '0;
            table_ready_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= '0;
            out_status_reg   <= ST_TAKEN;
            i_reg            <= '0;
            j_reg            <= '0;
            zdiv_reg         <= 1'b0;
            sat_reg          <= 1'b0;
            q_reg            <= '0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            cj_reg           <= '0;
            ci_reg           <= '0;
            xi_reg           <= '0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                node_count_reg   <= cfg_data;
                nodes_loaded_reg <= '0;
                table_ready_reg  <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_in) begin
                        if (!req.mode) begin
                            table_ready_reg <= 1'b0;
                            if (k_inc >= n) begin
                                // last node in: build the table
                                nodes_loaded_reg <= '0;
                                i_reg            <= n_m1;
                                j_reg            <= CW'(1);
                                zdiv_reg         <= 1'b0;
                                sat_reg          <= 1'b0;
                                state_reg        <= S_B_A;
                            end
                            else begin
                                nodes_loaded_reg <= k_inc;
                                out_valid_reg    <= 1'b1;
                                out_value_reg    <= '0;
                                out_status_reg   <= ST_TAKEN;
                            end
                        end
                        else if (!table_ready_reg) begin
                            out_valid_reg  <= 1'b1;
                            out_value_reg  <= '0;
                            out_status_reg <= ST_NOT_READY;
                        end
                        else begin
                            q_reg     <= req.query_x;
                            prod_reg  <= DW'(1) << FRAC_BITS;
                            sat_reg   <= 1'b0;
                            state_reg <= S_E_A;
                        end
                    end
                end
                S_B_A:
                begin
                    state_reg <= S_B_B;
                end
                S_B_B:
                begin
                    ci_reg    <= c_rd_reg;
                    xi_reg    <= x_rd_reg;
                    state_reg <= S_B_C;
                end
                S_B_C:
                begin
                    zdiv_reg <= zdiv_now;
                    if (!den_zero) begin
                        state_reg <= S_B_W;
                    end
                end
                S_B_W:
                begin
                    sat_reg <= sat_now;
                end
                S_E_A:
                begin
                    state_reg <= S_E_B;
                end
                S_E_B:
                begin
                    acc_reg   <= c_rd_reg;
                    j_reg     <= CW'(1);
                    state_reg <= S_E_RD;
                end
                S_E_RD:
                begin
                    state_reg <= S_E_M1;
                end
                S_E_M1:
                begin
                    cj_reg    <= c_rd_reg;
                    state_reg <= S_E_W1;
                end
                S_E_W1:
                begin
                    if (mul_done) begin
                        prod_reg  <= mul_res.value;
                        sat_reg   <= sat_reg || mul_res.sat;
                        state_reg <= S_E_W2;
                    end
                end
                S_E_W2:
                begin
                    if (mul_done) begin
                        acc_reg <= sum_val;
                        sat_reg <= q_sat;
                        if (j_reg == n_m1) begin
                            out_valid_reg  <= 1'b1;
                            out_value_reg  <= sum_val;
                            out_status_reg <= q_sat ? ST_SAT : ST_READY;
                            state_reg      <= S_IDLE;
                        end
                        else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // advance the build over i (downward) and column j
            if (step_done) begin
                if (i_reg == j_reg) begin
                    if (j_reg == n_m1) begin
                        table_ready_reg  <= 1'b1;
                        nodes_loaded_reg <= '0;
                        out_valid_reg    <= 1'b1;
                        out_value_reg    <= '0;
                        out_status_reg   <= zdiv_now ? ST_ZERO_DIV : (sat_now ? ST_SAT : ST_READY);
                        state_reg        <= S_IDLE;
                    end
                    else begin
                        j_reg     <= j_reg + 1'b1;
                        i_reg     <= n_m1;
                        state_reg <= S_B_A;
                    end
                end
                else begin
                    i_reg     <= i_reg - 1'b1;
                    state_reg <= S_B_A;
                end
            end
        end
    end

    // items are taken only by an idle sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("item taken while busy");

    // multiplier results arrive only where the evaluation waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_E_W1 || state_reg == S_E_W2))
        else $error("stray multiplier result");

    // divider results arrive only while the build waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_B_W)
        else $error("stray divider result");

    // a built table always restarts loading at the first node
    assert property (@(posedge clk) disable iff (!rst_n)
        table_ready_reg |-> nodes_loaded_reg == '0)
        else $error("loader count left over with table ready");

endmodule
